// ===== rtl/core/preemptive_priority_scheduler_unit_defines.svh =====
// Assertion macros shared by the checker of the priority scheduler.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PPS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pps: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define PPS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pps: next-cycle check failed");

`endif

// ===== rtl/core/pps_pkg.sv =====
`timescale 1ns / 1ps

package pps_pkg;

  localparam int DEF_MAX_PROCS = 16;
  localparam int DEF_TIME_BITS = 16;
  localparam int DEF_PRIO_BITS = 8;
  localparam int SUM_BITS      = 20;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Strobes broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic load_en;
    logic dec_en;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/pps_if.sv =====
`timescale 1ns / 1ps

// Command channel: load a process or advance time by one unit.
interface pps_req_if #(
  parameter int TIME_BITS = pps_pkg::DEF_TIME_BITS,
  parameter int PRIO_BITS = pps_pkg::DEF_PRIO_BITS
);
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [TIME_BITS-1:0] arrival_time;
  logic [TIME_BITS-1:0] burst_time;
  logic [PRIO_BITS-1:0] priority_req;

  modport source (output valid, command, arrival_time, burst_time, priority_req,
                  input ready);
  modport sink   (input valid, command, arrival_time, burst_time, priority_req,
                  output ready);
endinterface

// Result channel: one item for each tick.
interface pps_rsp_if #(
  parameter int TIME_BITS = pps_pkg::DEF_TIME_BITS,
  parameter int IDX_W     = $clog2(pps_pkg::DEF_MAX_PROCS)
);
  logic                         valid;
  logic                         ready;
  logic [TIME_BITS-1:0]         slot_start;
  logic [IDX_W-1:0]             running_index;
  logic                         idle;
  logic                         new_segment;
  logic                         finished;
  logic [TIME_BITS-1:0]         finish_time;
  logic [TIME_BITS-1:0]         turnaround;
  logic [TIME_BITS-1:0]         waiting;
  logic                         all_done;
  logic [pps_pkg::SUM_BITS-1:0] total_turnaround;
  logic [pps_pkg::SUM_BITS-1:0] total_waiting;

  modport source (output valid, slot_start, running_index, idle, new_segment, finished,
                  finish_time, turnaround, waiting, all_done, total_turnaround,
                  total_waiting,
                  input ready);
  modport sink   (input valid, slot_start, running_index, idle, new_segment, finished,
                  finish_time, turnaround, waiting, all_done, total_turnaround,
                  total_waiting,
                  output ready);
endinterface

// ===== rtl/core/pps_cell.sv =====
`timescale 1ns / 1ps

// One table slot of the scheduler. It compares its own process with the best
// candidate handed in from the lower slots and registers the winner for the
// next cell.
module pps_cell #(
  parameter int TIME_BITS  = pps_pkg::DEF_TIME_BITS,
  parameter int PRIO_BITS  = pps_pkg::DEF_PRIO_BITS,
  parameter int IDX_W      = 4,
  parameter int CNT_W      = 5,
  parameter int CELL_INDEX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  pps_pkg::cell_ctrl_t ctrl,
  input  logic [IDX_W-1:0]    wr_index,
  input  logic [IDX_W-1:0]    dec_index,
  input  logic [CNT_W-1:0]    loaded_count,
  input  logic [TIME_BITS-1:0] clock_now,
  input  logic [TIME_BITS-1:0] load_arrival,
  input  logic [TIME_BITS-1:0] load_burst,
  input  logic [PRIO_BITS-1:0] load_prio,
  input  logic                cand_in_found,
  input  logic [PRIO_BITS-1:0] cand_in_prio,
  input  logic [TIME_BITS-1:0] cand_in_arrival,
  input  logic [TIME_BITS-1:0] cand_in_burst,
  input  logic [TIME_BITS-1:0] cand_in_remaining,
  input  logic [IDX_W-1:0]    cand_in_index,
  output logic                cand_out_found,
  output logic [PRIO_BITS-1:0] cand_out_prio,
  output logic [TIME_BITS-1:0] cand_out_arrival,
  output logic [TIME_BITS-1:0] cand_out_burst,
  output logic [TIME_BITS-1:0] cand_out_remaining,
  output logic [IDX_W-1:0]    cand_out_index
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_INDEX);

  logic [TIME_BITS-1:0] arrival;
  logic [TIME_BITS-1:0] burst;
  logic [PRIO_BITS-1:0] prio;
  logic [TIME_BITS-1:0] remaining;

  logic ready_here;
  logic better;
  logic take;

  always_comb begin
    ready_here = (MY_CNT < loaded_count) && (arrival <= clock_now) && (remaining != '0);
    better     = !cand_in_found || (prio < cand_in_prio) ||
                 ((prio == cand_in_prio) && (arrival < cand_in_arrival));
    take       = ready_here && better;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_en && (wr_index == MY_IDX)) begin
      arrival   <= load_arrival;
      burst     <= load_burst;
      prio      <= load_prio;
      remaining <= load_burst;
    end else if (ctrl.dec_en && (dec_index == MY_IDX)) begin
      remaining <= remaining - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out_found <= 1'b0;
    end else begin
      cand_out_found <= take || cand_in_found;
    end
    if (take) begin
      cand_out_prio      <= prio;
      cand_out_arrival   <= arrival;
      cand_out_burst     <= burst;
      cand_out_remaining <= remaining;
      cand_out_index     <= MY_IDX;
    end else begin
      cand_out_prio      <= cand_in_prio;
      cand_out_arrival   <= cand_in_arrival;
      cand_out_burst     <= cand_in_burst;
      cand_out_remaining <= cand_in_remaining;
      cand_out_index     <= cand_in_index;
    end
  end

endmodule

// ===== rtl/core/preemptive_priority_scheduler_unit.sv =====
// A tick item's result is offered once the best-candidate word has rippled one slot
// cell per cycle down the chain and has then been committed to the output register.
// Throughput: one load per cycle while no tick is in progress; a tick holds off every
// new item until it commits, and a result still waiting in the output register holds
// the commit back until the sink takes it.
// Synchronous active-high reset clears the state registers; slot tables are undefined.
`timescale 1ns / 1ps

module preemptive_priority_scheduler_unit #(
  parameter int MAX_PROCS = pps_pkg::DEF_MAX_PROCS,
  parameter int TIME_BITS = pps_pkg::DEF_TIME_BITS,
  parameter int PRIO_BITS = pps_pkg::DEF_PRIO_BITS
) (
  input logic       clk,
  input logic       rst,
  pps_req_if.sink   req,
  pps_rsp_if.source rsp
);

  localparam int IDX_W  = $clog2(MAX_PROCS);
  localparam int CNT_W  = $clog2(MAX_PROCS + 1);
  localparam int SCAN_W = $clog2(MAX_PROCS);
  localparam int SUM_W  = pps_pkg::SUM_BITS;
  localparam int ADD_W  = ((TIME_BITS > SUM_W) ? TIME_BITS : SUM_W) + 1;

  localparam logic [TIME_BITS-1:0] TIME_MAX  = '1;
  localparam logic [SUM_W-1:0]     SUM_MAX   = '1;
  localparam logic [SCAN_W-1:0]    SCAN_LAST = SCAN_W'(MAX_PROCS - 1);
  localparam logic [CNT_W-1:0]     CNT_FULL  = CNT_W'(MAX_PROCS);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPDATE} state_t;

  state_t state;
  logic [SCAN_W-1:0] scan_count;

  // Scheduler state.
  logic [TIME_BITS-1:0] clock_now;
  logic [CNT_W-1:0]     loaded_count;
  logic [CNT_W-1:0]     done_count;
  logic                 last_valid;
  logic [IDX_W-1:0]     last_index;
  logic                 last_was_idle;
  logic [SUM_W-1:0]     sum_turnaround;
  logic [SUM_W-1:0]     sum_waiting;

  // Output register: the result item waits here until the sink takes it.
  logic                 out_valid;
  logic [TIME_BITS-1:0] o_slot_start;
  logic [IDX_W-1:0]     o_running_index;
  logic                 o_idle;
  logic                 o_new_segment;
  logic                 o_finished;
  logic [TIME_BITS-1:0] o_finish_time;
  logic [TIME_BITS-1:0] o_turnaround;
  logic [TIME_BITS-1:0] o_waiting;
  logic                 o_all_done;

  // The candidate word handed along the chain. Position 0 is the empty entry
  // fed into the first cell; position MAX_PROCS is the tail of the chain.
  logic                 c_found     [0:MAX_PROCS];
  logic [PRIO_BITS-1:0] c_prio      [0:MAX_PROCS];
  logic [TIME_BITS-1:0] c_arrival   [0:MAX_PROCS];
  logic [TIME_BITS-1:0] c_burst     [0:MAX_PROCS];
  logic [TIME_BITS-1:0] c_remaining [0:MAX_PROCS];
  logic [IDX_W-1:0]     c_index     [0:MAX_PROCS];

  pps_pkg::cell_ctrl_t ctrl;

  logic accept;
  logic load_ok;
  logic commit;

  logic                 all_before;
  logic                 run;
  logic                 fin_now;
  logic [TIME_BITS-1:0] clock_inc;
  logic [TIME_BITS-1:0] tat;
  logic [TIME_BITS-1:0] wt;
  logic [ADD_W-1:0]     tat_wide;
  logic [ADD_W-1:0]     wt_wide;
  logic [SUM_W-1:0]     sum_turnaround_next;
  logic [SUM_W-1:0]     sum_waiting_next;
  logic [CNT_W-1:0]     done_count_next;
  logic                 seg_next;

  assign c_found[0]     = 1'b0;
  assign c_prio[0]      = '0;
  assign c_arrival[0]   = '0;
  assign c_burst[0]     = '0;
  assign c_remaining[0] = '0;
  assign c_index[0]     = '0;

  // Items are taken only between ticks; the table and clock therefore stay
  // still for the whole ripple through the chain.
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign load_ok   = accept && (req.command == pps_pkg::CMD_LOAD) &&
                     (loaded_count < CNT_FULL) && (req.burst_time != '0);

  // A tick commits once the output register is free or being emptied.
  assign commit = (state == ST_UPDATE) && (!out_valid || rsp.ready);

  always_comb begin
    all_before = (done_count >= loaded_count);
    run        = !all_before && c_found[MAX_PROCS];
    fin_now    = run && (c_remaining[MAX_PROCS] == TIME_BITS'(1));
    clock_inc  = (clock_now == TIME_MAX) ? clock_now : clock_now + 1'b1;

    // The winner has arrived by the current clock, so this cannot wrap.
    tat = clock_inc - c_arrival[MAX_PROCS];
    wt  = (tat >= c_burst[MAX_PROCS]) ? tat - c_burst[MAX_PROCS] : '0;

    tat_wide = ADD_W'(sum_turnaround) + ADD_W'(tat);
    wt_wide  = ADD_W'(sum_waiting) + ADD_W'(wt);
    sum_turnaround_next = (tat_wide > ADD_W'(SUM_MAX)) ? SUM_MAX : tat_wide[SUM_W-1:0];
    sum_waiting_next    = (wt_wide > ADD_W'(SUM_MAX)) ? SUM_MAX : wt_wide[SUM_W-1:0];

    done_count_next = done_count + CNT_W'(fin_now);

    // A new chart segment starts whenever the runner changes, counting an
    // idle stretch as a runner of its own.
    if (run) begin
      seg_next = last_was_idle || !last_valid || (last_index != c_index[MAX_PROCS]);
    end else begin
      seg_next = !last_was_idle;
    end

    ctrl.load_en = load_ok;
    ctrl.dec_en  = commit && run;
  end

  for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
    pps_cell #(
      .TIME_BITS (TIME_BITS),
      .PRIO_BITS (PRIO_BITS),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W),
      .CELL_INDEX(g)
    ) u_cell (
      .clk               (clk),
      .rst               (rst),
      .ctrl              (ctrl),
      .wr_index          (loaded_count[IDX_W-1:0]),
      .dec_index         (c_index[MAX_PROCS]),
      .loaded_count      (loaded_count),
      .clock_now         (clock_now),
      .load_arrival      (req.arrival_time),
      .load_burst        (req.burst_time),
      .load_prio         (req.priority_req),
      .cand_in_found     (c_found[g]),
      .cand_in_prio      (c_prio[g]),
      .cand_in_arrival   (c_arrival[g]),
      .cand_in_burst     (c_burst[g]),
      .cand_in_remaining (c_remaining[g]),
      .cand_in_index     (c_index[g]),
      .cand_out_found    (c_found[g+1]),
      .cand_out_prio     (c_prio[g+1]),
      .cand_out_arrival  (c_arrival[g+1]),
      .cand_out_burst    (c_burst[g+1]),
      .cand_out_remaining(c_remaining[g+1]),
      .cand_out_index    (c_index[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      scan_count     <= '0;
      clock_now      <= '0;
      loaded_count   <= '0;
      done_count     <= '0;
      last_valid     <= 1'b0;
      last_index     <= '0;
      last_was_idle  <= 1'b0;
      sum_turnaround <= '0;
      sum_waiting    <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (load_ok) begin
            loaded_count <= loaded_count + 1'b1;
          end
          if (accept && (req.command == pps_pkg::CMD_TICK)) begin
            state      <= ST_SCAN;
            scan_count <= '0;
          end
        end
        ST_SCAN: begin
          // The scan counter runs over every cell of the chain.
          if (scan_count == SCAN_LAST) begin
            state <= ST_UPDATE;
          end else begin
            scan_count <= scan_count + 1'b1;
          end
        end
        ST_UPDATE: begin
          if (commit) begin
            state         <= ST_IDLE;
            out_valid     <= 1'b1;
            o_slot_start  <= clock_now;
            o_finished    <= fin_now;
            o_finish_time <= fin_now ? clock_inc : '0;
            o_turnaround  <= fin_now ? tat : '0;
            o_waiting     <= fin_now ? wt : '0;
            if (all_before) begin
              // Everything has completed: report the totals and hold the clock.
              o_running_index <= '0;
              o_idle          <= 1'b0;
              o_new_segment   <= 1'b0;
              o_all_done      <= 1'b1;
            end else begin
              clock_now       <= clock_inc;
              o_running_index <= run ? c_index[MAX_PROCS] : '0;
              o_idle          <= !run;
              o_new_segment   <= seg_next;
              o_all_done      <= (done_count_next >= loaded_count);
              last_was_idle   <= !run;
              last_valid      <= run;
              last_index      <= c_index[MAX_PROCS];
              if (fin_now) begin
                sum_turnaround <= sum_turnaround_next;
                sum_waiting    <= sum_waiting_next;
                done_count     <= done_count_next;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.slot_start       = o_slot_start;
  assign rsp.running_index    = o_running_index;
  assign rsp.idle             = o_idle;
  assign rsp.new_segment      = o_new_segment;
  assign rsp.finished         = o_finished;
  assign rsp.finish_time      = o_finish_time;
  assign rsp.turnaround       = o_turnaround;
  assign rsp.waiting          = o_waiting;
  assign rsp.all_done         = o_all_done;
  // The totals are sampled with the rest of the item; they only change on a
  // commit, which also refills the output register.
  assign rsp.total_turnaround = sum_turnaround;
  assign rsp.total_waiting    = sum_waiting;

endmodule

// ===== rtl/core/pps_checker.sv =====
`timescale 1ns / 1ps
`include "preemptive_priority_scheduler_unit_defines.svh"

// Watches the ports of the scheduler.
module pps_checker #(
  parameter int TIME_BITS = pps_pkg::DEF_TIME_BITS,
  parameter int IDX_W     = 4
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_ready,
  input logic                 req_command,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input logic [TIME_BITS-1:0] slot_start,
  input logic [IDX_W-1:0]     running_index,
  input logic                 idle,
  input logic                 finished,
  input logic [TIME_BITS-1:0] turnaround,
  input logic [TIME_BITS-1:0] waiting,
  input logic                 all_done
);

  `PPS_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(slot_start))
  `PPS_ASSERT_IMP(a_idle_clean, clk, rst, rsp_valid && idle, (running_index == '0) && !finished && !all_done)
  `PPS_ASSERT_IMP(a_wait_le_tat, clk, rst, rsp_valid && finished, waiting <= turnaround)
  `PPS_ASSERT_NXT(a_tick_busy, clk, rst, req_valid && req_ready && (req_command == pps_pkg::CMD_TICK), !req_ready)

endmodule

bind preemptive_priority_scheduler_unit pps_checker #(
  .TIME_BITS(TIME_BITS),
  .IDX_W    (IDX_W)
) u_pps_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_command  (req.command),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .slot_start   (rsp.slot_start),
  .running_index(rsp.running_index),
  .idle         (rsp.idle),
  .finished     (rsp.finished),
  .turnaround   (rsp.turnaround),
  .waiting      (rsp.waiting),
  .all_done     (rsp.all_done)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Testbench for the preemptive priority scheduler.
module tb_top;

  // Widths follow the block's defaults.
  localparam int TW          = pps_pkg::DEF_TIME_BITS;
  localparam int PW          = pps_pkg::DEF_PRIO_BITS;
  localparam int SLOTS       = pps_pkg::DEF_MAX_PROCS;
  localparam int IW          = $clog2(pps_pkg::DEF_MAX_PROCS);
  localparam int SUM_BITS    = pps_pkg::SUM_BITS;
  localparam int CYCLE_LIMIT = 300_000;
  // The limit leaves a wide margin over the whole run, even with the longest
  // gaps between items and the longest result stalls.

  localparam logic [4:0]          NO_RUNNER = 5'd31;
  localparam logic [TW-1:0]       TIME_TOP  = '1;
  localparam logic [SUM_BITS-1:0] SUM_TOP   = '1;

  // One result item of a tick, laid out as the result channel carries it.
  typedef struct packed {
    logic [TW-1:0]       slot_start;
    logic [IW-1:0]       running_index;
    logic                idle;
    logic                new_segment;
    logic                finished;
    logic [TW-1:0]       finish_time;
    logic [TW-1:0]       turnaround;
    logic [TW-1:0]       waiting;
    logic                all_done;
    logic [SUM_BITS-1:0] total_turnaround;
    logic [SUM_BITS-1:0] total_waiting;
  } tick_result_t;

  // The scoreboard keeps its own copy of the process table and scheduler
  // state. Each accepted tick adds the result the scheduler ought to give.
  class scheduler_scoreboard;
    logic [TW-1:0]       arrival_of[SLOTS];
    logic [TW-1:0]       burst_of[SLOTS];
    logic [PW-1:0]       prio_of[SLOTS];
    logic [TW-1:0]       left_of[SLOTS];
    logic [TW-1:0]       sched_clock = '0;
    int                  loaded_n    = 0;
    int                  done_n      = 0;
    logic [4:0]          prev_runner = NO_RUNNER;
    logic                prev_idle   = 1'b0;
    logic [SUM_BITS-1:0] sum_tat     = '0;
    logic [SUM_BITS-1:0] sum_wait    = '0;
    tick_result_t        pending_ticks[$];
    int                  errors      = 0;

    function void note_command(logic cmd, logic [TW-1:0] at, logic [TW-1:0] bt,
                               logic [PW-1:0] pr);
      tick_result_t r;
      int           sel;
      bit           found;
      logic [TW-1:0] tat;
      logic [TW-1:0] wt;
      int unsigned  acc;
      if (cmd == pps_pkg::CMD_LOAD) begin
        if (loaded_n < SLOTS && bt != '0) begin
          arrival_of[loaded_n] = at;
          burst_of[loaded_n]   = bt;
          prio_of[loaded_n]    = pr;
          left_of[loaded_n]    = bt;
          loaded_n++;
        end
        return;
      end
      r = '0;
      r.slot_start = sched_clock;
      if (done_n >= loaded_n) begin
        r.all_done         = 1'b1;
        r.total_turnaround = sum_tat;
        r.total_waiting    = sum_wait;
        pending_ticks.push_back(r);
        return;
      end
      sel   = 0;
      found = 1'b0;
      for (int i = 0; i < loaded_n; i++) begin
        if (arrival_of[i] <= sched_clock && left_of[i] != '0) begin
          if (!found || prio_of[i] < prio_of[sel] ||
              (prio_of[i] == prio_of[sel] && arrival_of[i] < arrival_of[sel])) begin
            sel   = i;
            found = 1'b1;
          end
        end
      end
      if (sched_clock != TIME_TOP) sched_clock++;
      if (!found) begin
        r.idle        = 1'b1;
        r.new_segment = !prev_idle;
        prev_idle     = 1'b1;
        prev_runner   = NO_RUNNER;
      end else begin
        r.running_index = sel[IW-1:0];
        r.new_segment   = prev_idle || (prev_runner != 5'(sel));
        prev_idle       = 1'b0;
        prev_runner     = 5'(sel);
        left_of[sel]--;
        if (left_of[sel] == '0) begin
          tat             = sched_clock - arrival_of[sel];
          wt              = (tat >= burst_of[sel]) ? tat - burst_of[sel] : '0;
          r.finished      = 1'b1;
          r.finish_time   = sched_clock;
          r.turnaround    = tat;
          r.waiting       = wt;
          acc             = sum_tat + tat;
          sum_tat         = (acc > SUM_TOP) ? SUM_TOP : acc[SUM_BITS-1:0];
          acc             = sum_wait + wt;
          sum_wait        = (acc > SUM_TOP) ? SUM_TOP : acc[SUM_BITS-1:0];
          done_n++;
        end
      end
      r.all_done         = (done_n >= loaded_n);
      r.total_turnaround = sum_tat;
      r.total_waiting    = sum_wait;
      pending_ticks.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_tick_result(tick_result_t got);
      tick_result_t want;
      if (pending_ticks.size() == 0) begin
        errors++;
        $display("%0t: result item with no tick outstanding, slot_start %0d",
                 $time, got.slot_start);
        return;
      end
      want = pending_ticks.pop_front();
      compare_field("slot_start", want.slot_start, got.slot_start);
      compare_field("running_index", want.running_index, got.running_index);
      compare_field("idle", want.idle, got.idle);
      compare_field("new_segment", want.new_segment, got.new_segment);
      compare_field("finished", want.finished, got.finished);
      compare_field("finish_time", want.finish_time, got.finish_time);
      compare_field("turnaround", want.turnaround, got.turnaround);
      compare_field("waiting", want.waiting, got.waiting);
      compare_field("all_done", want.all_done, got.all_done);
      compare_field("total_turnaround", want.total_turnaround, got.total_turnaround);
      compare_field("total_waiting", want.total_waiting, got.total_waiting);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  pps_req_if req_ch ();
  pps_rsp_if rsp_ch ();

  preemptive_priority_scheduler_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  scheduler_scoreboard sb = new();

  // When steady is set, neither side idles any more.
  bit steady       = 1'b0;
  int results_seen = 0;
  int cycle_count  = 0;

  always #6 clk = ~clk;

  // Offers one command item, optionally after a burst of idle cycles, and
  // waits until it has been accepted. The valid line is only lowered when a
  // gap is wanted, so back-to-back items keep it high without a glitch.
  task automatic issue(input logic cmd, input logic [TW-1:0] at,
                       input logic [TW-1:0] bt, input logic [PW-1:0] pr);
    if (!steady && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.command      <= cmd;
    req_ch.arrival_time <= at;
    req_ch.burst_time   <= bt;
    req_ch.priority_req <= pr;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_command(cmd, at, bt, pr);
  endtask

  // The load fields are meaningless on a tick, so they carry random noise.
  task automatic issue_tick();
    issue(pps_pkg::CMD_TICK, TW'($urandom), TW'($urandom), PW'($urandom));
  endtask

  task automatic issue_load(input logic [TW-1:0] at, input logic [TW-1:0] bt,
                            input logic [PW-1:0] pr);
    issue(pps_pkg::CMD_LOAD, at, bt, pr);
  endtask

  // Results are sampled at the rising edge, before any of this edge's
  // nonblocking updates have landed.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen <= results_seen + 1;
      sb.check_tick_result('{slot_start:       rsp_ch.slot_start,
                             running_index:    rsp_ch.running_index,
                             idle:             rsp_ch.idle,
                             new_segment:      rsp_ch.new_segment,
                             finished:         rsp_ch.finished,
                             finish_time:      rsp_ch.finish_time,
                             turnaround:       rsp_ch.turnaround,
                             waiting:          rsp_ch.waiting,
                             all_done:         rsp_ch.all_done,
                             total_turnaround: rsp_ch.total_turnaround,
                             total_waiting:    rsp_ch.total_waiting});
    end
  end

  // Result side back-pressure. Ready alternates between short low bursts and
  // longer high stretches. Once, after a couple of hundred results, it is
  // held low whilst the sender keeps offering ticks, so that the result
  // path fills and the command channel stalls.
  initial begin : result_drain
    int  level_left;
    bit  held_off;
    level_left = 0;
    held_off   = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held_off && results_seen >= 200) begin
        rsp_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        held_off = 1'b1;
      end else if (steady) begin
        rsp_ch.ready <= 1'b1;
      end else if (level_left > 0) begin
        level_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        rsp_ch.ready <= 1'b0;
        level_left = $urandom_range(1, 9) - 1;
      end else begin
        rsp_ch.ready <= 1'b1;
        level_left = $urandom_range(1, 40) - 1;
      end
    end
  end

  // A hung handshake ends the run here.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("preemptive_priority_scheduler_unit: mismatch");
    $finish;
  end

  initial begin : stimulus
    int            now;
    logic [TW-1:0] at;
    logic [TW-1:0] bt;
    logic [PW-1:0] pr;

    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.command      <= pps_pkg::CMD_LOAD;
    req_ch.arrival_time <= '0;
    req_ch.burst_time   <= '0;
    req_ch.priority_req <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. A tick on an empty table reports all_done without
    // moving the clock, and a load with a zero burst is dropped.
    issue_tick();
    issue_load('0, '0, '0);
    // Slots 0 and 1 tie on priority and arrival, so the lower slot runs
    // first. Slot 2 arrives at time 2 with the best priority and preempts.
    // Slot 3 arrives late at the worst priority, which leaves idle ticks in
    // between. Eleven ticks run the lot and a twelfth finds all done.
    issue_load(16'd0, 16'd3, 8'd4);
    issue_load(16'd0, 16'd2, 8'd4);
    issue_load(16'd2, 16'd2, 8'd0);
    issue_load(16'd10, 16'd1, 8'd255);
    repeat (12) issue_tick();
    // Loads after the table has drained bring all_done back down. The two
    // share a priority and the higher slot arrived earlier, so it wins.
    issue_load(16'd10, 16'd1, 8'd7);
    issue_load(16'd3, 16'd1, 8'd7);
    repeat (3) issue_tick();

    // Random part. With a single reset and sixteen slots the table is a
    // scarce resource, so work arrives in four waves of two processes each,
    // and each wave is followed by a long run of ticks. Arrivals lie mostly
    // just ahead of the clock, so late arrivals preempt the running process,
    // and priorities often collide so that the tie rules come into play.
    for (int w = 0; w < 4; w++) begin
      repeat (2) begin
        now = sb.sched_clock;
        if ($urandom_range(0, 9) < 7) at = TW'(now + $urandom_range(0, 60));
        else at = TW'($urandom_range(0, now));
        if ($urandom_range(0, 4) == 0) bt = TW'($urandom_range(1, 4));
        else bt = TW'($urandom_range(1, 200));
        if ($urandom_range(0, 1) == 0) pr = PW'($urandom_range(0, 3));
        else pr = PW'($urandom_range(0, 255));
        issue_load(at, bt, pr);
      end
      // Now and then a broken load with no burst, which must be dropped.
      if ($urandom_range(0, 1) == 1) issue_load(TW'($urandom), '0, PW'($urandom));
      repeat ($urandom_range(340, 400)) issue_tick();
    end

    // Closing part, with no idling on either side. The last two slots get
    // processes that arrive just ahead of the clock, the short one with the
    // best priority so that it preempts the long one, and a further load
    // finds the table full and is dropped. Ticking goes on until every
    // process has finished, then a few more ticks find everything done.
    steady = 1'b1;
    issue_load(sb.sched_clock + 16'd3, 16'd2, '0);
    issue_load(sb.sched_clock + 16'd1, 16'd20, '1);
    issue_load(TW'($urandom), TW'($urandom_range(1, 65535)), PW'($urandom));
    while (sb.done_n < sb.loaded_n) issue_tick();
    repeat (5) issue_tick();
    req_ch.valid <= 1'b0;

    while (sb.pending_ticks.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("preemptive_priority_scheduler_unit: match");
    end else begin
      $display("preemptive_priority_scheduler_unit: mismatch");
    end
    $finish;
  end

endmodule
